// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers. Define NO_ASSERTIONS to compile them away.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property must hold at every rising clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// consequent must hold whenever antecedent holds
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst_n, prop)
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- hdl/zsthin_pkg.sv -----
// ----------------------------------------------------------------------------
// zsthin_pkg
// Shared types and constants of the Zhang-Suen thinning pass.
// ----------------------------------------------------------------------------
package zsthin_pkg;

  // image geometry limits
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  // register and coordinate widths
  localparam int DIM_W   = 11;
  localparam int COORD_W = 10;

  // line store: must hold more than two full rows of history
  localparam int HIST_AW    = $clog2(2 * MAX_WIDTH + 1);
  localparam int HIST_DEPTH = 1 << HIST_AW;

  // neighbour count window for deletion
  localparam logic [3:0] MIN_SET = 4'd2;
  localparam logic [3:0] MAX_SET = 4'd6;

  // configuration register indexes
  typedef enum logic [1:0] {
    CfgWidth   = 2'd0,
    CfgHeight  = 2'd1,
    CfgSubIter = 2'd2
  } cfg_idx_e;

  // input word kinds
  typedef enum logic {
    OpPixel = 1'b0,
    OpFlush = 1'b1
  } opcode_e;

  // one window column: top row oldest, bottom row newest
  typedef struct packed {
    logic top;
    logic mid;
    logic bot;
  } col_t;

  // 3x3 window: newest column and the two before it
  typedef struct packed {
    col_t cur;
    col_t prev;
    col_t prev2;
  } win_t;

endpackage

// ----- hdl/thinning_pass_zhang_suen_core.sv -----
// ----------------------------------------------------------------------------
// thinning_pass_zhang_suen_core
// One Zhang-Suen thinning sub-iteration on a raster pixel stream.
// Latency: the result for pixel k leaves with the word accepted width+1 words
//   later, and passes the window stage and then the output register.
// Throughput: one word per cycle when not stalled, set by the store's write port.
// Reset: counters and handshakes clear; geometry 640x480, sub-iteration 0.
//   The line store needs no clearing: every judged window lies in the frame.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module thinning_pass_zhang_suen_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_idx_i,
  input  logic [zsthin_pkg::DIM_W-1:0]  cfg_data_i,
  // input words
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          opcode_i,
  input  logic                          pixel_in_i,
  // result words
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          pixel_out_o,
  output logic [zsthin_pkg::COORD_W-1:0] out_row_o,
  output logic [zsthin_pkg::COORD_W-1:0] out_col_o,
  output logic                          frame_last_o
);
  import zsthin_pkg::*;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] maxv);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) r = DIM_W'(1);
    else if (v > maxv) r = maxv;
    return r;
  endfunction

  // configuration registers (stored clamped)
  logic [DIM_W-1:0] eff_w_q, eff_h_q;
  logic             sub_iter_q;
  logic             geo_wr;

  // frame position
  logic               primed_q;
  logic [DIM_W-1:0]   prime_cnt_q;
  logic [COORD_W-1:0] row_q, col_q;

  // handshake
  logic in_acc, a_ready, out_ready;
  logic in_bit;
  logic is_last, is_inner, col_end;

  // window stage
  logic               a_valid_q;
  logic [COORD_W-1:0] a_row_q, a_col_q;
  logic               a_last_q, a_inner_q, a_sub_q;
  win_t               win;

  // judge
  logic [7:0] nbr, trans_vec;
  logic [3:0] trans_cnt, set_cnt;
  logic       m1, m2, erase, res_bit;

  // output register
  logic               out_valid_q;
  logic               pix_q, last_q;
  logic [COORD_W-1:0] orow_q, ocol_q;

  assign geo_wr = cfg_we_i && (cfg_idx_i == CfgWidth || cfg_idx_i == CfgHeight);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eff_w_q    <= DIM_W'(640);
      eff_h_q    <= DIM_W'(480);
      sub_iter_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgWidth:   eff_w_q    <= clamp_dim(cfg_data_i, DIM_W'(MAX_WIDTH));
        CfgHeight:  eff_h_q    <= clamp_dim(cfg_data_i, DIM_W'(MAX_HEIGHT));
        CfgSubIter: sub_iter_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // handshake: window stage drains into the output register
  assign out_ready  = !out_valid_q || !out_stall_i;
  assign a_ready    = !a_valid_q || out_ready;
  assign in_stall_o = !a_ready;
  assign in_acc     = in_valid_i && a_ready;

  // flush words enter as background
  assign in_bit = (opcode_e'(opcode_i) == OpPixel) ? pixel_in_i : 1'b0;

  // position of the pixel whose result this word releases
  assign col_end  = ({1'b0, col_q} == eff_w_q - DIM_W'(1));
  assign is_last  = col_end && ({1'b0, row_q} == eff_h_q - DIM_W'(1));
  assign is_inner = (row_q != '0) && ({1'b0, row_q} < eff_h_q - DIM_W'(1)) &&
                    (col_q != '0) && ({1'b0, col_q} < eff_w_q - DIM_W'(1));

  // frame counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      primed_q    <= 1'b0;
      prime_cnt_q <= '0;
      row_q       <= '0;
      col_q       <= '0;
    end else if (geo_wr) begin
      primed_q    <= 1'b0;
      prime_cnt_q <= '0;
      row_q       <= '0;
      col_q       <= '0;
    end else if (in_acc) begin
      if (!primed_q) begin
        if (prime_cnt_q == eff_w_q) begin
          primed_q    <= 1'b1;
          prime_cnt_q <= '0;
        end else begin
          prime_cnt_q <= prime_cnt_q + DIM_W'(1);
        end
      end else if (is_last) begin
        primed_q <= 1'b0;
        row_q    <= '0;
        col_q    <= '0;
      end else if (col_end) begin
        col_q <= '0;
        row_q <= row_q + COORD_W'(1);
      end else begin
        col_q <= col_q + COORD_W'(1);
      end
    end
  end

  zsthin_line_store u_line_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_acc),
    .bit_i   (in_bit),
    .width_i (eff_w_q),
    .win_o   (win)
  );

  // window stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (a_ready) begin
      a_valid_q <= in_acc && primed_q;
    end
  end

  // window stage payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      a_row_q   <= row_q;
      a_col_q   <= col_q;
      a_last_q  <= is_last;
      a_inner_q <= is_inner;
      a_sub_q   <= sub_iter_q;
    end
  end

  // neighbours P2..P9 in ring order N, NE, E, SE, S, SW, W, NW
  assign nbr = {win.prev2.top, win.prev2.mid, win.prev2.bot, win.prev.bot,
                win.cur.bot, win.cur.mid, win.cur.top, win.prev.top};
  assign trans_vec = ~nbr & {nbr[0], nbr[7:1]};
  assign trans_cnt = 4'($countones(trans_vec));
  assign set_cnt   = 4'($countones(nbr));

  // deletion rule of the selected sub-iteration
  always_comb begin
    if (!a_sub_q) begin
      m1 = nbr[0] & nbr[2] & nbr[4];
      m2 = nbr[2] & nbr[4] & nbr[6];
    end else begin
      m1 = nbr[0] & nbr[2] & nbr[6];
      m2 = nbr[0] & nbr[4] & nbr[6];
    end
    erase   = a_inner_q && (trans_cnt == 4'd1) &&
              (set_cnt inside {[MIN_SET:MAX_SET]}) && !m1 && !m2;
    res_bit = win.prev.mid && !erase;
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && a_valid_q) begin
      pix_q  <= res_bit;
      orow_q <= a_row_q;
      ocol_q <= a_col_q;
      last_q <= a_last_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign pixel_out_o  = pix_q;
  assign out_row_o    = orow_q;
  assign out_col_o    = ocol_q;
  assign frame_last_o = last_q;

  // counters stay parked while priming and inside the frame afterwards
  `ASSERT_IMPLY(a_park_pos, clk_i, rst_ni, !primed_q, (row_q == '0) && (col_q == '0))
  `ASSERT_IMPLY(a_col_range, clk_i, rst_ni, primed_q, {1'b0, col_q} < eff_w_q)
  `ASSERT_IMPLY(a_row_range, clk_i, rst_ni, primed_q, {1'b0, row_q} < eff_h_q)
  `ASSERT_ALWAYS(a_prime_range, clk_i, rst_ni, prime_cnt_q <= eff_w_q)

endmodule

// ----- hdl/zsthin_line_store.sv -----
// ----------------------------------------------------------------------------
// zsthin_line_store
// Circular bit store of the pixel stream with two row taps and a 3x3 window.
// ----------------------------------------------------------------------------
module zsthin_line_store (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  input  logic                        bit_i,
  input  logic [zsthin_pkg::DIM_W-1:0] width_i,
  output zsthin_pkg::win_t            win_o
);
  import zsthin_pkg::*;

  logic               mem [HIST_DEPTH];
  logic [HIST_AW-1:0] wptr_q, wptr_d;
  logic [HIST_AW-1:0] addr_one, addr_two;
  logic               rd_one_q, rd_two_q, bit_q;
  col_t               prev_q, prev2_q;

  // taps one and two rows back from the word being written
  assign addr_one = wptr_q - HIST_AW'(width_i);
  assign addr_two = wptr_q - HIST_AW'({width_i, 1'b0});
  assign wptr_d   = wptr_q + HIST_AW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
    end else if (push_i) begin
      wptr_q <= wptr_d;
    end
  end

  // store write and registered tap reads
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wptr_q] <= bit_i;
      rd_one_q    <= mem[addr_one];
      rd_two_q    <= mem[addr_two];
    end
  end

  // newest bit and column shift
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      bit_q   <= bit_i;
      prev_q  <= win_o.cur;
      prev2_q <= prev_q;
    end
  end

  assign win_o.cur   = '{top: rd_two_q, mid: rd_one_q, bot: bit_q};
  assign win_o.prev  = prev_q;
  assign win_o.prev2 = prev2_q;

endmodule

// ----- test/thin_pass_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thin_pass_checker
// Watches the register port and both word channels of the thinning pass.
// Keeps its own line store and geometry, predicts each output pixel when the
// input word that releases it is taken, and compares every output word with
// the oldest prediction.
// ----------------------------------------------------------------------------
module thin_pass_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // register port
  input  logic                           cfg_we_i,
  input  logic [1:0]                     cfg_idx_i,
  input  logic [zsthin_pkg::DIM_W-1:0]   cfg_data_i,
  // input words
  input  logic                           in_valid_i,
  input  logic                           in_stall_i,
  input  logic                           opcode_i,
  input  logic                           pixel_in_i,
  // output words
  input  logic                           out_valid_i,
  input  logic                           out_stall_i,
  input  logic                           pixel_out_i,
  input  logic [zsthin_pkg::COORD_W-1:0] out_row_i,
  input  logic [zsthin_pkg::COORD_W-1:0] out_col_i,
  input  logic                           frame_last_i,
  // status for the test top
  output int unsigned                    fail_count_o,
  output int unsigned                    pending_o,
  output int unsigned                    words_o,
  output int unsigned                    pixels_o,
  output int unsigned                    cleared_o
);
  import zsthin_pkg::*;

  // two full rows plus three words of history cover every window
  localparam int unsigned HIST_LEN   = 2 * MAX_WIDTH + 3;
  localparam int unsigned REPORT_MAX = 10;

  // neighbour slots in ring order around the center
  localparam int NbN  = 0;
  localparam int NbNE = 1;
  localparam int NbE  = 2;
  localparam int NbSE = 3;
  localparam int NbS  = 4;
  localparam int NbSW = 5;
  localparam int NbW  = 6;
  localparam int NbNW = 7;

  typedef struct packed {
    logic               pix;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               last;
  } thin_px_t;

  logic [DIM_W-1:0] width_q;
  logic [DIM_W-1:0] height_q;
  logic             sub_q;
  logic             line_bits [HIST_LEN];
  int unsigned      wr_ptr;
  int unsigned      seen;
  thin_px_t         due_px_q [$];
  int unsigned      fails;
  int unsigned      n_words;
  int unsigned      n_pixels;
  int unsigned      n_cleared;

  function automatic int unsigned clamp_dim(logic [DIM_W-1:0] v, int unsigned lim);
    if (v == '0) return 1;
    if (v > lim) return lim;
    return v;
  endfunction

  // bit that entered 'back' words before the newest one
  function automatic logic tap(int unsigned back);
    int unsigned newest;
    newest = (wr_ptr + HIST_LEN - 1) % HIST_LEN;
    return line_bits[(newest + HIST_LEN - back) % HIST_LEN];
  endfunction

  task automatic clear_model();
    for (int i = 0; i < HIST_LEN; i++) line_bits[i] = 1'b0;
    width_q   = 11'd640;
    height_q  = 11'd480;
    sub_q     = 1'b0;
    wr_ptr    = 0;
    seen      = 0;
    fails     = 0;
    n_words   = 0;
    n_pixels  = 0;
    n_cleared = 0;
    due_px_q.delete();
  endtask

  // geometry writes restart the frame, the line store keeps its bits
  task automatic apply_cfg(logic [1:0] idx, logic [DIM_W-1:0] val);
    case (idx)
      CfgWidth: begin
        width_q = val;
        seen    = 0;
      end
      CfgHeight: begin
        height_q = val;
        seen     = 0;
      end
      CfgSubIter: begin
        sub_q = val[0];
      end
      default: ;
    endcase
  endtask

  // one taken input word: shift it in and predict the pixel it releases
  task automatic judge_word(logic op, logic pix);
    int unsigned w, h, total, n, o, r, c, trans, nset;
    logic        centre, res, m1, m2;
    logic        nb [8];
    thin_px_t    px;
    w     = clamp_dim(width_q, MAX_WIDTH);
    h     = clamp_dim(height_q, MAX_HEIGHT);
    total = w * h;
    n_words++;
    line_bits[wr_ptr] = (op == OpPixel) ? pix : 1'b0;
    wr_ptr = (wr_ptr + 1) % HIST_LEN;
    n    = seen;
    seen = n + 1;
    if (n < w + 1) return;
    o = n - (w + 1);
    if (o >= total) begin
      seen = 0;
      return;
    end
    r      = o / w;
    c      = o % w;
    centre = tap(w + 1);
    res    = centre;
    // interior pixels only; borders pass through
    if (r >= 1 && r + 2 <= h && c >= 1 && c + 2 <= w) begin
      nb[NbN]  = tap(2 * w + 1);
      nb[NbNE] = tap(2 * w);
      nb[NbE]  = tap(w);
      nb[NbSE] = tap(0);
      nb[NbS]  = tap(1);
      nb[NbSW] = tap(2);
      nb[NbW]  = tap(w + 2);
      nb[NbNW] = tap(2 * w + 2);
      trans = 0;
      nset  = 0;
      for (int i = 0; i < 8; i++) begin
        if (!nb[i] && nb[(i + 1) % 8]) trans++;
        if (nb[i]) nset++;
      end
      if (sub_q == 1'b0) begin
        m1 = nb[NbN] & nb[NbE] & nb[NbS];
        m2 = nb[NbE] & nb[NbS] & nb[NbW];
      end else begin
        m1 = nb[NbN] & nb[NbE] & nb[NbW];
        m2 = nb[NbN] & nb[NbS] & nb[NbW];
      end
      if (trans == 1 && nset >= MIN_SET && nset <= MAX_SET && !m1 && !m2) res = 1'b0;
    end
    if (centre && !res) n_cleared++;
    px.pix  = res;
    px.row  = r[COORD_W-1:0];
    px.col  = c[COORD_W-1:0];
    px.last = (o + 1 == total);
    if (px.last) seen = 0;
    due_px_q = {due_px_q, px};
  endtask

  task automatic check_pixel();
    thin_px_t got, want;
    got = {pixel_out_i, out_row_i, out_col_i, frame_last_i};
    n_pixels++;
    if (due_px_q.size() == 0) begin
      fails++;
      if (fails <= REPORT_MAX)
        $display("%0t: pixel word with none predicted: px=%0d row=%0d col=%0d last=%0d",
                 $time, got.pix, got.row, got.col, got.last);
    end else begin
      want = due_px_q.pop_front();
      if (got.pix !== want.pix || got.row !== want.row || got.col !== want.col ||
          got.last !== want.last) begin
        fails++;
        if (fails <= REPORT_MAX)
          $display("%0t: pixel mismatch: want px=%0d row=%0d col=%0d last=%0d, got px=%0d row=%0d col=%0d last=%0d",
                   $time, want.pix, want.row, want.col, want.last,
                   got.pix, got.row, got.col, got.last);
      end
    end
  endtask

  // output side first: a word released at this edge cannot leave at it
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_model();
    end else begin
      if (out_valid_i && !out_stall_i) check_pixel();
      if (cfg_we_i) apply_cfg(cfg_idx_i, cfg_data_i);
      if (in_valid_i && !in_stall_i) judge_word(opcode_i, pixel_in_i);
    end
    fail_count_o <= fails;
    pending_o    <= due_px_q.size();
    words_o      <= n_words;
    pixels_o     <= n_pixels;
    cleared_o    <= n_cleared;
  end

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Test top of the Zhang-Suen thinning pass. Streams frames of many shapes and
// sizes with random gaps and output stalls, switches geometry and
// sub-iteration between and inside frames, and leaves checking to the
// checker beside the block.
// ----------------------------------------------------------------------------
module tb;
  import zsthin_pkg::*;

  localparam int unsigned RAND_WORDS = 500;
  localparam int unsigned NEVER      = 32'hFFFF_FFFF;
  // register index the block does not decode
  localparam logic [1:0]  CfgSpare   = 2'd3;
  // 3x3 frame, raster order from the msb: center with set N, NE, E, SE, S
  localparam logic [8:0]  EDGE_3X3   = 9'b011_011_011;

  logic               clk_i        = 1'b0;
  logic               rst_ni       = 1'b0;
  logic               cfg_we_i     = 1'b0;
  logic [1:0]         cfg_idx_i    = '0;
  logic [DIM_W-1:0]   cfg_data_i   = '0;
  logic               in_valid_i   = 1'b0;
  logic               in_stall_o;
  logic               opcode_i     = 1'b0;
  logic               pixel_in_i   = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i  = 1'b0;
  logic               pixel_out_o;
  logic [COORD_W-1:0] out_row_o;
  logic [COORD_W-1:0] out_col_o;
  logic               frame_last_o;

  int unsigned fail_cnt, pend_cnt, words_cnt, pixels_cnt, cleared_cnt;
  int unsigned words_sent = 0;
  int unsigned burst_left = 0;
  logic        sub_now    = 1'b0;

  // current frame shape
  logic        box_mode;
  int unsigned fill_pct;
  int unsigned box_r0, box_r1, box_c0, box_c1;

  thinning_pass_zhang_suen_core dut (
    .clk_i, .rst_ni,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .opcode_i, .pixel_in_i,
    .out_valid_o, .out_stall_i, .pixel_out_o, .out_row_o, .out_col_o, .frame_last_o
  );

  thin_pass_checker u_check (
    .clk_i, .rst_ni,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_stall_i(in_stall_o), .opcode_i, .pixel_in_i,
    .out_valid_i(out_valid_o), .out_stall_i, .pixel_out_i(pixel_out_o),
    .out_row_i(out_row_o), .out_col_i(out_col_o), .frame_last_i(frame_last_o),
    .fail_count_o(fail_cnt), .pending_o(pend_cnt), .words_o(words_cnt),
    .pixels_o(pixels_cnt), .cleared_o(cleared_cnt)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // mostly short gaps, a few long ones
  function automatic int unsigned gap_len();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic pick_shape(int unsigned w, int unsigned h);
    int unsigned a, b;
    box_mode = ($urandom_range(0, 2) == 0);
    case ($urandom_range(0, 2))
      0:       fill_pct = 20;
      1:       fill_pct = 50;
      default: fill_pct = 80;
    endcase
    a = $urandom_range(0, h - 1);
    b = $urandom_range(0, h - 1);
    box_r0 = (a < b) ? a : b;
    box_r1 = (a < b) ? b : a;
    a = $urandom_range(0, w - 1);
    b = $urandom_range(0, w - 1);
    box_c0 = (a < b) ? a : b;
    box_c1 = (a < b) ? b : a;
  endtask

  function automatic logic next_pixel(int unsigned r, int unsigned c);
    logic in_box;
    if (!box_mode) return ($urandom_range(0, 99) < fill_pct);
    in_box = (r >= box_r0 && r <= box_r1 && c >= box_c0 && c <= box_c1);
    // sparse noise roughens the box outline
    if ($urandom_range(0, 29) == 0) return !in_box;
    return in_box;
  endfunction

  // present one word and hold it until the block takes it
  task automatic send_word(opcode_e op, logic pix);
    int unsigned gap;
    if (burst_left > 0) begin
      gap = 0;
      burst_left--;
    end else begin
      gap = gap_len();
      if ($urandom_range(0, 39) == 0) burst_left = $urandom_range(20, 100);
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i   <= op;
    pixel_in_i <= pix;
    do @(posedge clk_i); while (in_stall_o);
    words_sent++;
  endtask

  // drain all predicted pixels, then a short pause for words without output
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pend_cnt != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [DIM_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // one frame plus its tail; may stop early or flip the sub-iteration midway
  task automatic stream_frame(int unsigned w, int unsigned h, int unsigned cut,
                              int unsigned flip_at);
    int unsigned total;
    total = w * h;
    for (int unsigned k = 0; k < total + w + 1 && k < cut; k++) begin
      if (k == flip_at) begin
        settle();
        sub_now = ~sub_now;
        write_reg(CfgSubIter, DIM_W'(sub_now));
      end
      if (k < total) begin
        if ($urandom_range(0, 24) == 0) send_word(OpFlush, 1'($urandom_range(0, 1)));
        else send_word(OpPixel, next_pixel(k / w, k % w));
      end else begin
        send_word(opcode_e'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  initial begin : out_backpressure
    int unsigned run, hold;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 120) : $urandom_range(1, 6);
      out_stall_i <= 1'b0;
      repeat (run) @(posedge clk_i);
      hold = gap_len();
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
    end
  end

  initial begin : stimulus
    int unsigned w, h, nimg, cut, flip, rand_start, spin;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset geometry: just past the first-row delay of a 640 wide frame
    repeat (643) send_word(OpPixel, 1'($urandom_range(0, 1)));
    settle();

    // 3x3 edge point: kept by the first rule, cleared by the second
    write_reg(CfgWidth, DIM_W'(3));
    write_reg(CfgHeight, DIM_W'(3));
    sub_now = 1'b0;
    write_reg(CfgSubIter, DIM_W'(sub_now));
    for (int k = 0; k < 9; k++) send_word(OpPixel, EDGE_3X3[8 - k]);
    send_word(OpFlush, 1'b1);
    send_word(OpPixel, 1'b1);
    send_word(OpFlush, 1'b0);
    send_word(OpPixel, 1'b0);
    settle();
    write_reg(CfgSpare, 11'h7FF);
    sub_now = 1'b1;
    write_reg(CfgSubIter, DIM_W'(sub_now));
    // flush in the frame with its pixel bit set, pixel words in the tail
    send_word(OpFlush, 1'b1);
    for (int k = 1; k < 9; k++) send_word(OpPixel, EDGE_3X3[8 - k]);
    repeat (4) send_word(OpPixel, 1'b1);
    settle();

    // zero geometry clamps to a single pixel
    write_reg(CfgWidth, DIM_W'(0));
    write_reg(CfgHeight, DIM_W'(0));
    sub_now = 1'b0;
    write_reg(CfgSubIter, DIM_W'(sub_now));
    pick_shape(1, 1);
    stream_frame(1, 1, NEVER, NEVER);
    stream_frame(1, 1, NEVER, NEVER);
    settle();

    // tallest column, height written above the limit, cut short
    write_reg(CfgWidth, DIM_W'(1));
    write_reg(CfgHeight, 11'h7FF);
    pick_shape(1, MAX_HEIGHT);
    stream_frame(1, MAX_HEIGHT, 40, NEVER);

    // random frames, mostly small, some cut short or switched midway
    rand_start = words_sent;
    while (words_sent - rand_start < RAND_WORDS) begin
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      h = $urandom_range(1, 10);
      settle();
      if ($urandom_range(0, 9) == 0) write_reg(CfgSpare, DIM_W'($urandom_range(0, 2047)));
      write_reg(CfgWidth, DIM_W'(w));
      write_reg(CfgHeight, DIM_W'(h));
      sub_now = 1'($urandom_range(0, 1));
      write_reg(CfgSubIter, DIM_W'(sub_now));
      nimg = $urandom_range(1, 3);
      for (int unsigned i = 0; i < nimg; i++) begin
        pick_shape(w, h);
        cut  = ($urandom_range(0, 9) == 0) ? $urandom_range(1, w * h + w) : NEVER;
        flip = ($urandom_range(0, 9) == 0) ? $urandom_range(1, w * h) : NEVER;
        stream_frame(w, h, cut, flip);
        if (cut != NEVER) break;
      end
    end

    // drain with a bound, then allow the output stage to go quiet
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    for (spin = 0; spin < 50000 && pend_cnt != 0; spin++) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("streamed %0d words in, checked %0d pixel words, %0d foreground pixels cleared",
             words_cnt, pixels_cnt, cleared_cnt);
    $display("reset 640 wide geometry, clamped geometry, random frames up to 40 wide, both rules, flush in and after frames");
    if (pend_cnt != 0) $display("%0d predicted pixels never came out", pend_cnt);
    if (fail_cnt == 0 && pend_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin : watchdog
    #25ms;
    $display("simulation failed");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/zsthin_pkg.sv
hdl/zsthin_line_store.sv
hdl/thinning_pass_zhang_suen_core.sv
test/thin_pass_checker.sv
test/tb.sv
